>>> sv/timed_soft_start_motor_driver_top_assert.svh
// Assertion macros for the timed soft-start motor driver.
// Used by the core and the top level; no other dependencies.
// The macros expect signals named clk and arst_n in the including module.
`ifndef TIMED_SOFT_START_MOTOR_DRIVER_TOP_ASSERT_SVH
`define TIMED_SOFT_START_MOTOR_DRIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSSMD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tssmd assertion failed");

// Next-cycle implication.
`define TSSMD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tssmd assertion failed");

`endif

>>> sv/tssmd_pkg.sv
// Shared types and codes for the timed soft-start motor driver.
// No dependencies; imported by the register block, the core and the top level.
package tssmd_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_RAMP_INTERVAL = 2'd0;
	localparam logic [1:0] REG_LINK_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_MOVE_SPEED    = 2'd2;

	// Reset values of the registers.
	localparam logic [7:0]  RAMP_INTERVAL_RST = 8'd2;
	localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd2000;
	localparam logic [7:0]  MOVE_SPEED_RST    = 8'd200;

	// Item modes.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_MOVE = 2'd1;

	// Move kinds.
	localparam logic [2:0] DIR_FWD   = 3'd0;
	localparam logic [2:0] DIR_BACK  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_STOP  = 3'd4;

	// Bridge codes.
	localparam logic [1:0] BRIDGE_OFF = 2'd0;
	localparam logic [1:0] BRIDGE_FWD = 2'd1;
	localparam logic [1:0] BRIDGE_REV = 2'd2;

	typedef struct packed {
		logic [7:0]  ramp_step_ms;
		logic [15:0] link_timeout_ms;
		logic [7:0]  move_speed;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  direction;
		logic [15:0] move_len;
	} item_t;

	typedef struct packed {
		logic [7:0] pwm_left;
		logic [7:0] pwm_right;
		logic [1:0] drive_left;
		logic [1:0] drive_right;
		logic       move_ack;
		logic       timer_expired;
		logic       link_lost;
	} res_t;

endpackage

>>> sv/timed_soft_start_motor_driver_top.sv
// Top level of the timed soft-start two-motor driver: input register, core, result register.
// Depends on tssmd_pkg, tssmd_regs, tssmd_core and the assertion macro header.
//
//   Channel   Direction  Handshake              Contents
//   cfg       in         psel/penable/pready    ramp interval, link timeout, move speed
//   in        in         in_valid/in_ready      mode, direction, move_len
//   out       out        out_valid/out_ready    pwm, drive, move_ack, timer_expired, link_lost
//
// Each item is held in the input register and is then evaluated against the
// motor state in a single pass; its result lands in the output register on the same
// edge that commits the new state. One item is taken per cycle while the output is
// not stalled. A stalled output holds its result; the input register still accepts
// one more item behind it. Reset is asynchronous and active low and clears the valid
// flags, the motor state and the configuration, leaving the registers at their documented defaults.
module timed_soft_start_motor_driver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tssmd_pkg::ADDR_W-1:0]  paddr,
	input  logic [tssmd_pkg::DATA_W-1:0]  pwdata,
	output logic [tssmd_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	// Input items.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [2:0]                    direction,
	input  logic [15:0]                   move_len,
	// Result items.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    pwm_left,
	output logic [7:0]                    pwm_right,
	output logic [1:0]                    drive_left,
	output logic [1:0]                    drive_right,
	output logic                          move_ack,
	output logic                          timer_expired,
	output logic                          link_lost
);
	import tssmd_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	logic  in_fire;

	tssmd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The item in the input register is processed when the output register can take
	// its result; the state update and the result capture share that edge.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.mode      <= mode;
			item_s1.direction <= direction;
			item_s1.move_len  <= move_len;
		end
	end

	tssmd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign pwm_left      = res_s2.pwm_left;
	assign pwm_right     = res_s2.pwm_right;
	assign drive_left    = res_s2.drive_left;
	assign drive_right   = res_s2.drive_right;
	assign move_ack      = res_s2.move_ack;
	assign timer_expired = res_s2.timer_expired;
	assign link_lost     = res_s2.link_lost;

`include "timed_soft_start_motor_driver_top_assert.svh"

	// A command never reports tick events in the same result.
	`TSSMD_ASSERT_IMP(a_ack_alone, (out_valid && move_ack), (!timer_expired && !link_lost))
	// A watchdog stop shows both motors halted and unpowered.
	`TSSMD_ASSERT_IMP(a_lost_halts, (out_valid && link_lost), (pwm_left == 8'd0 && pwm_right == 8'd0 && drive_left == BRIDGE_OFF && drive_right == BRIDGE_OFF))
	// With both registers full and the output stalled, nothing more is taken.
	`TSSMD_ASSERT_IMP(a_full_blocks, (valid_s1 && valid_s2 && !out_ready), (!in_ready))
	// An empty input register always accepts.
	`TSSMD_ASSERT_IMP(a_empty_accepts, (!valid_s1), (in_ready))

endmodule

>>> sv/tssmd_regs.sv
// APB configuration registers of the timed soft-start motor driver.
// Depends on tssmd_pkg for the register indexes, reset values and cfg_t.
module tssmd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tssmd_pkg::ADDR_W-1:0]  paddr,
	input  logic [tssmd_pkg::DATA_W-1:0]  pwdata,
	output logic [tssmd_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output tssmd_pkg::cfg_t               cfg
);
	import tssmd_pkg::*;

	logic       wr_en;
	logic [1:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step_ms     <= RAMP_INTERVAL_RST;
			cfg_q.link_timeout_ms  <= LINK_TIMEOUT_RST;
			cfg_q.move_speed       <= MOVE_SPEED_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RAMP_INTERVAL: cfg_q.ramp_step_ms     <= pwdata[7:0];
				REG_LINK_TIMEOUT:  cfg_q.link_timeout_ms  <= pwdata[15:0];
				REG_MOVE_SPEED:    cfg_q.move_speed       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RAMP_INTERVAL: prdata = {24'd0, cfg_q.ramp_step_ms};
			REG_LINK_TIMEOUT:  prdata = {16'd0, cfg_q.link_timeout_ms};
			REG_MOVE_SPEED:    prdata = {24'd0, cfg_q.move_speed};
			default:           prdata = '0;
		endcase
	end

endmodule

>>> sv/tssmd_core.sv
// Motor state and per-item update logic of the timed soft-start motor driver.
// Depends on tssmd_pkg and on the assertion macro header.
module tssmd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tssmd_pkg::item_t  item,
	input  tssmd_pkg::cfg_t   cfg,
	output tssmd_pkg::res_t   res
);
	import tssmd_pkg::*;

	logic [31:0] now_q, last_link_q, move_end_q, last_step_q;
	logic        armed_q;
	logic [7:0]  duty_l_q, duty_r_q, goal_l_q, goal_r_q;
	logic [1:0]  bridge_l_q, bridge_r_q;

	logic [31:0] now_d, last_link_d, move_end_d, last_step_d;
	logic        armed_d;
	logic [7:0]  duty_l_d, duty_r_d, goal_l_d, goal_r_d;
	logic [1:0]  bridge_l_d, bridge_r_d;
	logic        ack, done, lost;
	logic [31:0] now_inc, silence, past, since_step;

	function automatic logic [7:0] ramp_one(input logic [7:0] cur, input logic [7:0] goal);
		logic [7:0] nxt;
		if (cur < goal)
			nxt = cur + 8'd1;
		else if (cur > goal)
			nxt = cur - 8'd1;
		else
			nxt = cur;
		return nxt;
	endfunction

	assign now_inc    = now_q + 32'd1;
	assign silence    = now_inc - last_link_q;
	assign past       = now_inc - move_end_q;
	assign since_step = now_inc - last_step_q;

	always_comb begin
		now_d       = now_q;
		last_link_d = last_link_q;
		move_end_d  = move_end_q;
		last_step_d = last_step_q;
		armed_d     = armed_q;
		duty_l_d    = duty_l_q;
		duty_r_d    = duty_r_q;
		goal_l_d    = goal_l_q;
		goal_r_d    = goal_r_q;
		bridge_l_d  = bridge_l_q;
		bridge_r_d  = bridge_r_q;
		ack         = 1'b0;
		done        = 1'b0;
		lost        = 1'b0;
		if (item.mode == MODE_TICK) begin
			now_d = now_inc;
			// Watchdog: stop running motors after too long a silence.
			if (silence > {16'd0, cfg.link_timeout_ms} &&
			    (goal_l_q != 8'd0 || goal_r_q != 8'd0)) begin
				goal_l_d   = 8'd0;
				goal_r_d   = 8'd0;
				duty_l_d   = 8'd0;
				duty_r_d   = 8'd0;
				bridge_l_d = BRIDGE_OFF;
				bridge_r_d = BRIDGE_OFF;
				lost       = 1'b1;
			end
			// Move timer: expired once now lies strictly after the end time.
			if (armed_q && past != 32'd0 && !past[31]) begin
				goal_l_d = 8'd0;
				goal_r_d = 8'd0;
				armed_d  = 1'b0;
				done     = 1'b1;
			end
			if (since_step >= {24'd0, cfg.ramp_step_ms}) begin
				last_step_d = now_inc;
				duty_l_d    = ramp_one(duty_l_d, goal_l_d);
				duty_r_d    = ramp_one(duty_r_d, goal_r_d);
			end
		end else if (item.mode == MODE_MOVE) begin
			last_link_d = now_q;
			move_end_d  = now_q + {16'd0, item.move_len};
			armed_d     = 1'b1;
			ack         = 1'b1;
			case (item.direction)
				DIR_FWD: begin
					bridge_l_d = BRIDGE_FWD;
					bridge_r_d = BRIDGE_FWD;
					goal_l_d   = cfg.move_speed;
					goal_r_d   = cfg.move_speed;
				end
				DIR_BACK: begin
					bridge_l_d = BRIDGE_REV;
					bridge_r_d = BRIDGE_REV;
					goal_l_d   = cfg.move_speed;
					goal_r_d   = cfg.move_speed;
				end
				DIR_LEFT: begin
					bridge_l_d = BRIDGE_REV;
					bridge_r_d = BRIDGE_FWD;
					goal_l_d   = cfg.move_speed;
					goal_r_d   = cfg.move_speed;
				end
				DIR_RIGHT: begin
					bridge_l_d = BRIDGE_FWD;
					bridge_r_d = BRIDGE_REV;
					goal_l_d   = cfg.move_speed;
					goal_r_d   = cfg.move_speed;
				end
				DIR_STOP: begin
					goal_l_d   = 8'd0;
					goal_r_d   = 8'd0;
					duty_l_d   = 8'd0;
					duty_r_d   = 8'd0;
					bridge_l_d = BRIDGE_OFF;
					bridge_r_d = BRIDGE_OFF;
				end
				default: ;
			endcase
		end else begin
			last_link_d = now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			last_link_q <= '0;
			move_end_q  <= '0;
			last_step_q <= '0;
			armed_q     <= 1'b0;
			duty_l_q    <= '0;
			duty_r_q    <= '0;
			goal_l_q    <= '0;
			goal_r_q    <= '0;
			bridge_l_q  <= BRIDGE_OFF;
			bridge_r_q  <= BRIDGE_OFF;
		end else if (fire) begin
			now_q       <= now_d;
			last_link_q <= last_link_d;
			move_end_q  <= move_end_d;
			last_step_q <= last_step_d;
			armed_q     <= armed_d;
			duty_l_q    <= duty_l_d;
			duty_r_q    <= duty_r_d;
			goal_l_q    <= goal_l_d;
			goal_r_q    <= goal_r_d;
			bridge_l_q  <= bridge_l_d;
			bridge_r_q  <= bridge_r_d;
		end
	end

	assign res.pwm_left      = duty_l_d;
	assign res.pwm_right     = duty_r_d;
	assign res.drive_left    = bridge_l_d;
	assign res.drive_right   = bridge_r_d;
	assign res.move_ack      = ack;
	assign res.timer_expired = done;
	assign res.link_lost     = lost;

`include "timed_soft_start_motor_driver_top_assert.svh"

	// A nonzero goal is only ever set together with both bridges.
	`TSSMD_ASSERT_IMP(a_goal_has_bridge, (goal_l_q != 8'd0 || goal_r_q != 8'd0), (bridge_l_q != BRIDGE_OFF && bridge_r_q != BRIDGE_OFF))

endmodule

>>> test/timed_soft_start_motor_driver_top_tb.sv
// Self-checking testbench for the timed soft-start two-motor driver top level.
// Needs tssmd_pkg and timed_soft_start_motor_driver_top; predicts every result in a
// small scoreboard class and drives the item and APB ports with plain tasks.
module timed_soft_start_motor_driver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tssmd_pkg::*;

	// Modes and move kinds that the package leaves unnamed. The spare mode behaves as
	// a keepalive, and move kinds past stop are accepted but leave the motors alone.
	localparam logic [1:0] MODE_KEEPALIVE = 2'd2;
	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam logic [2:0] DIR_UNDEF_LO   = 3'd5;
	localparam logic [2:0] DIR_UNDEF_HI   = 3'd7;

	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 316;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 4;

	// Scoreboard: carries its own copy of the register settings and the motor state,
	// works out the result of every accepted item and queues it for the output check.
	class motor_scoreboard;
		cfg_t        cfg;
		bit   [31:0] now_ms;
		bit   [31:0] link_ms;
		bit   [31:0] end_ms;
		bit   [31:0] step_ms;
		bit          armed;
		bit   [7:0]  duty_l;
		bit   [7:0]  duty_r;
		bit   [7:0]  goal_l;
		bit   [7:0]  goal_r;
		bit   [1:0]  bridge_l;
		bit   [1:0]  bridge_r;
		res_t        owed_outputs[$];
		int          mismatches;

		function new();
			cfg = {RAMP_INTERVAL_RST, LINK_TIMEOUT_RST, MOVE_SPEED_RST};
			bridge_l = BRIDGE_OFF;
			bridge_r = BRIDGE_OFF;
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t ns: %s", $time, msg);
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
			REG_RAMP_INTERVAL: cfg.ramp_step_ms = value[7:0];
			REG_LINK_TIMEOUT:  cfg.link_timeout_ms = value[15:0];
			REG_MOVE_SPEED:    cfg.move_speed = value[7:0];
			default: ;
			endcase
		endfunction

		function void halt_motors();
			goal_l = '0;
			goal_r = '0;
			duty_l = '0;
			duty_r = '0;
			bridge_l = BRIDGE_OFF;
			bridge_r = BRIDGE_OFF;
		endfunction

		function void steer(logic [1:0] left, logic [1:0] right);
			bridge_l = left;
			bridge_r = right;
			goal_l = cfg.move_speed;
			goal_r = cfg.move_speed;
		endfunction

		function bit [7:0] ramp_toward(bit [7:0] cur, bit [7:0] goal);
			if (cur < goal) begin
				return cur + 8'd1;
			end
			if (cur > goal) begin
				return cur - 8'd1;
			end
			return cur;
		endfunction

		function void take_item(item_t it);
			res_t       want;
			bit  [31:0] silence;
			bit  [31:0] past;
			bit  [31:0] since_step;
			want = '0;
			case (it.mode)
			MODE_TICK: begin
				now_ms++;
				silence = now_ms - link_ms;
				if (silence > {16'd0, cfg.link_timeout_ms} && (goal_l != 0 || goal_r != 0)) begin
					halt_motors();
					want.link_lost = 1'b1;
				end
				// The move is over once the clock is strictly past its end time.
				past = now_ms - end_ms;
				if (armed && past != 0 && !past[31]) begin
					goal_l = '0;
					goal_r = '0;
					armed = 1'b0;
					want.timer_expired = 1'b1;
				end
				since_step = now_ms - step_ms;
				if (since_step >= {24'd0, cfg.ramp_step_ms}) begin
					step_ms = now_ms;
					duty_l = ramp_toward(duty_l, goal_l);
					duty_r = ramp_toward(duty_r, goal_r);
				end
			end
			MODE_MOVE: begin
				link_ms = now_ms;
				end_ms = now_ms + {16'd0, it.move_len};
				armed = 1'b1;
				case (it.direction)
				DIR_FWD:   steer(BRIDGE_FWD, BRIDGE_FWD);
				DIR_BACK:  steer(BRIDGE_REV, BRIDGE_REV);
				DIR_LEFT:  steer(BRIDGE_REV, BRIDGE_FWD);
				DIR_RIGHT: steer(BRIDGE_FWD, BRIDGE_REV);
				DIR_STOP:  halt_motors();
				default: ;
				endcase
				want.move_ack = 1'b1;
			end
			default: link_ms = now_ms;
			endcase
			want.pwm_left = duty_l;
			want.pwm_right = duty_r;
			want.drive_left = bridge_l;
			want.drive_right = bridge_r;
			owed_outputs.push_back(want);
		endfunction

		function void check_output(res_t got);
			res_t want;
			if (owed_outputs.size() == 0) begin
				note_mismatch($sformatf("output with nothing owed: pwm %0d/%0d drive %0d/%0d",
					got.pwm_left, got.pwm_right, got.drive_left, got.drive_right));
				return;
			end
			want = owed_outputs.pop_front();
			if (got.pwm_left !== want.pwm_left || got.pwm_right !== want.pwm_right ||
					got.drive_left !== want.drive_left || got.drive_right !== want.drive_right ||
					got.move_ack !== want.move_ack || got.timer_expired !== want.timer_expired ||
					got.link_lost !== want.link_lost) begin
				note_mismatch($sformatf(
					"pwm %0d/%0d drive %0d/%0d ack %0b done %0b lost %0b, got %0d/%0d %0d/%0d %b %b %b",
					want.pwm_left, want.pwm_right, want.drive_left, want.drive_right,
					want.move_ack, want.timer_expired, want.link_lost,
					got.pwm_left, got.pwm_right, got.drive_left, got.drive_right,
					got.move_ack, got.timer_expired, got.link_lost));
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           mode;
	logic [2:0]           direction;
	logic [15:0]          move_len;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           pwm_left;
	logic [7:0]           pwm_right;
	logic [1:0]           drive_left;
	logic [1:0]           drive_right;
	logic                 move_ack;
	logic                 timer_expired;
	logic                 link_lost;

	motor_scoreboard sb;

	// Idle rates in percent for each side, and the length of a forced receiver stall.
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_left;
	int cycles;

	timed_soft_start_motor_driver_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.direction     (direction),
		.move_len      (move_len),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pwm_left      (pwm_left),
		.pwm_right     (pwm_right),
		.drive_left    (drive_left),
		.drive_right   (drive_right),
		.move_ack      (move_ack),
		.timer_expired (timer_expired),
		.link_lost     (link_lost)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on the whole run: a hung handshake ends here as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver side. A forced stall, when one is requested, holds ready low for its whole
	// length so that the result register and then the input register fill up; otherwise
	// ready drops at the current idle rate.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Every result that crosses the output handshake is checked against the oldest
	// prediction still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_output({pwm_left, pwm_right, drive_left, drive_right,
				move_ack, timer_expired, link_lost});
		end
	end

	// Offers one item, after an optional random gap, and holds it until it is taken.
	// Called and returning just after a falling edge; the prediction is made at the
	// rising edge that accepts the item, well before its result can come out.
	task automatic send_item(input logic [1:0] m, input logic [2:0] d, input logic [15:0] dur);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		direction <= d;
		move_len <= dur;
		do @(posedge clk); while (!in_ready);
		sb.take_item({m, d, dur});
		@(negedge clk);
	endtask

	// Writes one register through the APB port, with junk above the register's width,
	// then reads it back and checks the value that the register kept.
	task automatic program_reg(input logic [1:0] idx, input logic [15:0] setting);
		logic [31:0] value;
		logic [15:0] kept;
		logic [15:0] want_back;
		value = $urandom;
		if (idx == REG_LINK_TIMEOUT) begin
			value[15:0] = setting;
			want_back = setting;
		end else begin
			value[7:0] = setting[7:0];
			want_back = {8'h00, setting[7:0]};
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		// Back-to-back read of the same register: new setup phase, psel stays high.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		kept = (idx == REG_LINK_TIMEOUT) ? prdata[15:0] : {8'h00, prdata[7:0]};
		if (kept !== want_back) begin
			sb.note_mismatch($sformatf("register %0d reads %0h, expected %0h",
				idx, kept, want_back));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Drops valid and waits until every owed result has come out, and then for the
	// two-stage pipeline to go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.owed_outputs.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		int          k;
		int          sent;
		int          pick;
		int          run;
		logic [7:0]  ramp_setting;
		logic [15:0] timeout_setting;
		logic [7:0]  speed_setting;
		logic [2:0]  d;
		logic [15:0] dur;

		sb = new();
		cycles = 0;
		stall_left = 0;
		tx_idle_pct = 19;
		rx_idle_pct = 55;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = MODE_TICK;
		direction = DIR_FWD;
		move_len = '0;
		out_ready = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, on the reset settings (ramp every 2 ms, watchdog 2000 ms,
		// speed 200). A zero-length move at time zero must still expire on the first tick.
		send_item(MODE_MOVE, DIR_FWD, 16'd0);
		send_item(MODE_TICK, DIR_FWD, 16'd0);
		// Longest move, then ticks with every ignored field bit set: the duties ramp up.
		send_item(MODE_MOVE, DIR_BACK, 16'hFFFF);
		repeat (6) send_item(MODE_TICK, DIR_UNDEF_HI, 16'hFFFF);
		// Keepalives, including the unused mode, only restart the watchdog.
		send_item(MODE_KEEPALIVE, DIR_STOP, 16'h5555);
		send_item(MODE_SPARE, DIR_LEFT, 16'hAAAA);
		// Turns re-aim the bridges and keep the ramped duty; a short move is replaced before it runs out.
		send_item(MODE_MOVE, DIR_LEFT, 16'd2);
		repeat (2) send_item(MODE_TICK, DIR_FWD, 16'd0);
		send_item(MODE_MOVE, DIR_RIGHT, 16'h5555);
		// Unknown move kinds arm the timer and ack but leave the motors as they are.
		send_item(MODE_MOVE, DIR_UNDEF_LO, 16'hAAAA);
		send_item(MODE_MOVE, DIR_UNDEF_HI, 16'd1);
		repeat (3) send_item(MODE_TICK, DIR_BACK, 16'h0F0F);
		// Stop clears everything at once but still acks and arms the timer.
		send_item(MODE_MOVE, DIR_STOP, 16'd3);
		repeat (4) send_item(MODE_TICK, DIR_RIGHT, 16'hF0F0);
		settle();

		// Random part. Each phase reprograms all three registers, extremes first, then
		// small speeds and short watchdogs so that ramps finish, moves time out and the
		// watchdog trips often, and fully random settings last.
		for (k = 0; k < PHASES; k++) begin
			case (k)
			0: begin
				ramp_setting = 8'd1;
				timeout_setting = 16'd1;
				speed_setting = 8'd255;
			end
			1: begin
				ramp_setting = 8'd255;
				timeout_setting = 16'hFFFF;
				speed_setting = 8'd0;
			end
			2: begin
				// A zero ramp interval steps on every tick; a zero watchdog trips on any
				// tick after a command while a goal is set.
				ramp_setting = 8'd0;
				timeout_setting = 16'd0;
				speed_setting = 8'd1;
			end
			3: begin
				ramp_setting = 8'($urandom_range(4, 1));
				timeout_setting = 16'($urandom_range(60, 5));
				speed_setting = 8'($urandom_range(20, 1));
			end
			4: begin
				ramp_setting = 8'd1;
				timeout_setting = 16'($urandom_range(80, 20));
				speed_setting = 8'($urandom_range(12, 3));
			end
			default: begin
				ramp_setting = 8'($urandom);
				timeout_setting = 16'($urandom);
				speed_setting = 8'($urandom);
			end
			endcase
			program_reg(REG_RAMP_INTERVAL, {8'h00, ramp_setting});
			program_reg(REG_LINK_TIMEOUT, timeout_setting);
			program_reg(REG_MOVE_SPEED, {8'h00, speed_setting});

			// Receiver-heavy idling first, then sender-heavy, then none at all.
			if (k < 2) begin
				tx_idle_pct = 19;
				rx_idle_pct = 55;
			end else if (k < 4) begin
				tx_idle_pct = 55;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			// Long receiver stall while the sender keeps offering: the block must
			// back-pressure its input without losing or reordering anything.
			if (k == 4) begin
				@(posedge clk);
				stall_left = 400;
				@(negedge clk);
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					// A quiet stretch of ticks lets ramps settle and the watchdog expire.
					run = $urandom_range(60, 5);
					repeat (run) send_item(MODE_TICK, 3'($urandom), 16'($urandom));
					sent += run;
				end else if (pick < 55) begin
					send_item(MODE_TICK, 3'($urandom), 16'($urandom));
					sent++;
				end else if (pick < 85) begin
					if ($urandom_range(9) == 0) begin
						d = 3'($urandom_range(DIR_UNDEF_HI, DIR_UNDEF_LO));
					end else begin
						d = 3'($urandom_range(DIR_STOP, DIR_FWD));
					end
					case ($urandom_range(19))
					0: dur = 16'($urandom);
					1: dur = 16'hFFFF;
					default: dur = 16'($urandom_range(40));
					endcase
					send_item(MODE_MOVE, d, dur);
					sent++;
				end else begin
					send_item($urandom_range(1) ? MODE_KEEPALIVE : MODE_SPARE,
						3'($urandom), 16'($urandom));
					sent++;
				end
			end
			settle();
		end

		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
